FILE: design/cursor_linked_list_engine_macros.svh
// Assertion helpers shared by the RTL.
// Each one samples on i_clk and is disabled while i_rst_n is low.
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define CLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLL_ASSERT_IMP(lbl, ante, cons, msg)
`define CLL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/cll_pkg.sv
package cll_pkg;

    localparam int CLL_NODES = 8;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic nxt_we;
    } t_store_ctl;

endpackage

FILE: design/cll_if.sv
interface cll_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface cll_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

FILE: design/cll_store.sv
module cll_store import cll_pkg::*; #(
    parameter int NODES = CLL_NODES,
    localparam int IW = $clog2(NODES),
    localparam int PW = $clog2(NODES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_store_ctl    i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_val_waddr,
    input  logic [7:0]    i_val_wdata,
    input  logic [IW-1:0] i_nxt_waddr,
    input  logic [PW-1:0] i_nxt_wdata,
    output logic [7:0]    o_rd_value,
    output logic [PW-1:0] o_rd_next
);

    logic [7:0]       r_val_mem [NODES];
    logic [PW-1:0]    r_nxt_mem [NODES];
    logic [NODES-1:0] r_nvld;

    logic [7:0]    r_rd_value;
    logic [PW-1:0] r_rd_next_raw;
    logic          r_rd_nvld;
    logic [IW-1:0] r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_val_mem[i_val_waddr] <= i_val_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_value <= r_val_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.nxt_we) begin
            r_nxt_mem[i_nxt_waddr] <= i_nxt_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_next_raw <= r_nxt_mem[i_rd_addr];
            r_rd_nvld     <= r_nvld[i_rd_addr];
            r_rd_addr     <= i_rd_addr;
        end
    end

    // A link never written since reset reads as its reset chain: i -> i+1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= '0;
        end else if (i_ctl.nxt_we) begin
            r_nvld[i_nxt_waddr] <= 1'b1;
        end
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_next  = r_rd_nvld ? r_rd_next_raw : (PW'(r_rd_addr) + PW'(1));

endmodule

FILE: design/cursor_linked_list_engine.sv
// Channel   Dir  Modport  Payload
// i_cmd     in   sink     command[1:0], value[7:0]
// o_res     out  source   status[1:0], data[7:0], last
//
// One link is followed per cycle (registered node-store read) while the walk is not stalled.
// Insert appends a popped free node at the tail; delete unlinks the first node with the value.
// Read out: after the head read, one element per cycle while results drain.
// Reset clears the list and free-list heads and the link valid bits directly; no sweep.
// A result held in the output register stalls the read-out walk; i_cmd is ready only between commands.
module cursor_linked_list_engine import cll_pkg::*; #(
    parameter int NODES = CLL_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cll_cmd_if.sink     i_cmd,
    cll_res_if.source   o_res
);

`include "cursor_linked_list_engine_macros.svh"

    localparam int IW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NULL_IDX = PW'(NODES);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_POP  = 3'd1;
    localparam logic [2:0] S_INS_WALK = 3'd2;
    localparam logic [2:0] S_DEL_WALK = 3'd3;
    localparam logic [2:0] S_DEL_FREE = 3'd4;
    localparam logic [2:0] S_RD_WALK  = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    function automatic logic is_node(input logic [PW-1:0] idx);
        return idx < NULL_IDX;
    endfunction

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_free_head, n_free_head;
    logic [PW-1:0] r_list_head, n_list_head;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_prev, n_prev;
    logic          r_have_prev, n_have_prev;
    logic [PW-1:0] r_steps, n_steps;
    logic [PW-1:0] r_slot, n_slot;
    logic [7:0]    r_value, n_value;
    logic [1:0]    r_status, n_status;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [7:0]    r_out_data;
    logic          r_out_last;

    logic          out_load;
    logic [1:0]    out_status;
    logic [7:0]    out_data;
    logic          out_last;
    logic          slot_free;
    logic          cmd_accept;

    t_store_ctl    ctl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] val_waddr;
    logic [7:0]    val_wdata;
    logic [IW-1:0] nxt_waddr;
    logic [PW-1:0] nxt_wdata;
    logic [7:0]    rd_value;
    logic [PW-1:0] rd_next;
    logic [PW-1:0] steps_inc;
    logic          walk_more;

    cll_store #(.NODES(NODES)) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_rd_addr   (rd_addr),
        .i_val_waddr (val_waddr),
        .i_val_wdata (val_wdata),
        .i_nxt_waddr (nxt_waddr),
        .i_nxt_wdata (nxt_wdata),
        .o_rd_value  (rd_value),
        .o_rd_next   (rd_next)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign steps_inc   = r_steps + PW'(1);
    assign walk_more   = (steps_inc < NULL_IDX) && is_node(rd_next);

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_list_head = r_list_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_steps     = r_steps;
        n_slot      = r_slot;
        n_value     = r_value;
        n_status    = r_status;

        ctl        = '0;
        rd_addr    = '0;
        val_waddr  = r_slot[IW-1:0];
        val_wdata  = r_value;
        nxt_waddr  = r_cur[IW-1:0];
        nxt_wdata  = NULL_IDX;

        out_load   = 1'b0;
        out_status = ST_OK;
        out_data   = '0;
        out_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_accept) begin
                    n_value     = i_cmd.value;
                    n_steps     = '0;
                    n_have_prev = 1'b0;
                    n_cur       = r_list_head;
                    unique case (i_cmd.command)
                        CMD_INSERT: begin
                            if (!is_node(r_free_head)) begin
                                n_status = ST_FULL;
                                n_state  = S_EMIT;
                            end else begin
                                n_slot    = r_free_head;
                                ctl.rd_en = 1'b1;
                                rd_addr   = r_free_head[IW-1:0];
                                n_state   = S_INS_POP;
                            end
                        end
                        CMD_DELETE, CMD_READ: begin
                            if (!is_node(r_list_head)) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                ctl.rd_en = 1'b1;
                                rd_addr   = r_list_head[IW-1:0];
                                n_state   = (i_cmd.command == CMD_DELETE) ? S_DEL_WALK
                                                                          : S_RD_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_POP: begin
                // rd_next holds the link of the popped free node
                n_free_head = rd_next;
                ctl.val_we  = 1'b1;
                ctl.nxt_we  = 1'b1;
                nxt_waddr   = r_slot[IW-1:0];
                nxt_wdata   = NULL_IDX;
                if (!is_node(r_list_head)) begin
                    n_list_head = r_slot;
                    n_status    = ST_OK;
                    n_state     = S_EMIT;
                end else begin
                    n_cur     = r_list_head;
                    ctl.rd_en = 1'b1;
                    rd_addr   = r_list_head[IW-1:0];
                    n_state   = S_INS_WALK;
                end
            end
            S_INS_WALK: begin
                if ((r_steps < NULL_IDX) && is_node(rd_next)) begin
                    n_cur     = rd_next;
                    n_steps   = steps_inc;
                    ctl.rd_en = 1'b1;
                    rd_addr   = rd_next[IW-1:0];
                end else begin
                    ctl.nxt_we = 1'b1;
                    nxt_waddr  = r_cur[IW-1:0];
                    nxt_wdata  = r_slot;
                    n_status   = ST_OK;
                    n_state    = S_EMIT;
                end
            end
            S_DEL_WALK: begin
                if (rd_value == r_value) begin
                    if (r_have_prev) begin
                        ctl.nxt_we = 1'b1;
                        nxt_waddr  = r_prev[IW-1:0];
                        nxt_wdata  = rd_next;
                    end else begin
                        n_list_head = rd_next;
                    end
                    n_state = S_DEL_FREE;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_steps     = steps_inc;
                    n_cur       = rd_next;
                    if (walk_more) begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = rd_next[IW-1:0];
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_DEL_FREE: begin
                // final link write of the unlink: node goes to the free-list head
                ctl.nxt_we  = 1'b1;
                nxt_waddr   = r_cur[IW-1:0];
                nxt_wdata   = r_free_head;
                n_free_head = r_cur;
                n_status    = ST_OK;
                n_state     = S_EMIT;
            end
            S_RD_WALK: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_data   = rd_value;
                    out_last   = !walk_more;
                    if (walk_more) begin
                        n_cur     = rd_next;
                        n_steps   = steps_inc;
                        ctl.rd_en = 1'b1;
                        rd_addr   = rd_next[IW-1:0];
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_list_head <= NULL_IDX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_list_head <= n_list_head;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_steps     <= n_steps;
        r_slot      <= n_slot;
        r_value     <= n_value;
        r_status    <= n_status;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_data   <= out_data;
            r_out_last   <= out_last;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.data   = r_out_data;
    assign o_res.last   = r_out_last;

    `CLL_ASSERT_IMP(a_heads_disjoint, is_node(r_list_head), r_list_head != r_free_head, "list and free heads share a node")
    `CLL_ASSERT_IMP(a_walk_on_node, r_state == S_INS_WALK || r_state == S_DEL_WALK || r_state == S_RD_WALK, is_node(r_cur), "walk cursor off the store")
    `CLL_ASSERT_IMP(a_ins_not_self, r_state == S_INS_WALK, r_cur != r_slot, "insert walk reached the new node")
    `CLL_ASSERT_NXT(a_unused_cmd_idle, cmd_accept && i_cmd.command == CMD_NONE, r_state == S_IDLE && !out_load, "unused command left idle")

endmodule
